// File: design/smdc_pkg.sv
// ----------------------------------------------------------------------------
// smdc_pkg
// Shared types for the sliding window median / absolute deviation cost core.
// ----------------------------------------------------------------------------
package smdc_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COST_W   = 43;
  localparam int unsigned WSIZE_W  = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_of_sequence;
  } in_beat_t;

  typedef struct packed {
    logic        [COST_W-1:0]   window_cost;
    logic signed [SAMPLE_W-1:0] window_median;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PRIME,
    ST_MERGE,
    ST_COMMIT
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic prime;
    logic step;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic merge_done;
    logic out_busy;
  } dp_status_t;

endpackage

// File: design/smdc_ram.sv
// ----------------------------------------------------------------------------
// smdc_ram
// Simple dual port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smdc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/smdc_ctrl.sv
// ----------------------------------------------------------------------------
// smdc_ctrl
// Sequencer: accept a sample, fetch the oldest, run the sorted merge pass,
// then commit the result once the output register is free.
// ----------------------------------------------------------------------------
module smdc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  smdc_pkg::dp_status_t status_i,
  output smdc_pkg::dp_cmd_t    cmd_o
);
  import smdc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_PRIME;
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = ST_MERGE;
      end
      ST_MERGE: begin
        cmd_o.step = 1'b1;
        if (status_i.merge_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: design/smdc_datapath.sv
// ----------------------------------------------------------------------------
// smdc_datapath
// Arrival ring, ping-pong sorted window banks, merge pass and cost assembly.
// ----------------------------------------------------------------------------
module smdc_datapath #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [10:0]            cfg_wdata_i,
  input  smdc_pkg::in_beat_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output smdc_pkg::out_beat_t    out_data_o,
  input  smdc_pkg::dp_cmd_t      cmd_i,
  output smdc_pkg::dp_status_t   status_o
);
  import smdc_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned ACC_W = SAMPLE_W + AW + 2;

  logic [WSIZE_W-1:0]         wsize_q;
  logic [CW-1:0]              w_eff, m_idx;
  logic [CW-1:0]              fill_q, n_q, fill_c, ptr_c, fill_new;
  logic [CW-1:0]              j_q, j_d, k_q, k_d, ptr_inc;
  logic [AW-1:0]              ptr_q;
  logic                       start_q, bank_q, remove_en_q;
  logic                       rem_done_q, rem_done_d, ins_done_q, ins_done_d;
  logic signed [SAMPLE_W-1:0] v_q, r_q, med_q, x, wr_val;
  logic signed [ACC_W-1:0]    low_q, high_q, cost_s;
  logic                       wr_en, avail, result;
  logic [SAMPLE_W-1:0]        ring_rdata, rd0, rd1;
  logic [AW-1:0]              srt_raddr;
  logic                       out_valid_q;
  out_beat_t                  out_q;

  // clamp window size to 1..MAX_WINDOW
  always_comb begin
    if (wsize_q == '0) begin
      w_eff = CW'(1);
    end else if (32'(wsize_q) > MAX_WINDOW) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(wsize_q);
    end
    m_idx = (w_eff - CW'(1)) >> 1;
  end

  always_comb begin
    fill_c = start_q ? '0 : fill_q;
    ptr_c  = start_q ? '0 : CW'(ptr_q);
    if (ptr_c >= w_eff) begin
      ptr_c = '0;
    end
  end

  smdc_ram #(.DEPTH(MAX_WINDOW), .WIDTH(SAMPLE_W)) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.prime),
    .waddr_i (ptr_q),
    .wdata_i (v_q),
    .raddr_i (ptr_c[AW-1:0]),
    .rdata_o (ring_rdata)
  );

  // merge: drop the oldest once, slot the new sample in ahead of larger values
  always_comb begin
    j_d        = j_q;
    k_d        = k_q;
    rem_done_d = rem_done_q;
    ins_done_d = ins_done_q;
    wr_en      = 1'b0;
    wr_val     = v_q;
    x          = bank_q ? $signed(rd1) : $signed(rd0);
    avail      = (j_q < n_q);
    if (cmd_i.step) begin
      if (avail && remove_en_q && !rem_done_q && (x == r_q)) begin
        j_d        = j_q + CW'(1);
        rem_done_d = 1'b1;
      end else if (!ins_done_q && (!avail || (x > v_q))) begin
        wr_en      = 1'b1;
        k_d        = k_q + CW'(1);
        ins_done_d = 1'b1;
      end else if (avail) begin
        wr_en  = 1'b1;
        wr_val = x;
        j_d    = j_q + CW'(1);
        k_d    = k_q + CW'(1);
      end
    end
    srt_raddr = cmd_i.step ? j_d[AW-1:0] : '0;
  end

  smdc_ram #(.DEPTH(MAX_WINDOW), .WIDTH(SAMPLE_W)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (wr_en & bank_q),
    .waddr_i (k_q[AW-1:0]),
    .wdata_i (wr_val),
    .raddr_i (srt_raddr),
    .rdata_o (rd0)
  );

  smdc_ram #(.DEPTH(MAX_WINDOW), .WIDTH(SAMPLE_W)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (wr_en & ~bank_q),
    .waddr_i (k_q[AW-1:0]),
    .wdata_i (wr_val),
    .raddr_i (srt_raddr),
    .rdata_o (rd1)
  );

  assign fill_new = remove_en_q ? n_q : n_q + CW'(1);
  assign result   = (fill_new == w_eff);
  assign ptr_inc  = (CW'(ptr_q) + CW'(1) >= w_eff) ? '0 : CW'(ptr_q) + CW'(1);

  // above-median sum minus below-median sum; an even window has one extra
  // element above, worth one median
  assign cost_s = high_q - low_q - (w_eff[0] ? ACC_W'(0) : ACC_W'(med_q));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q     <= WSIZE_W'(1);
      fill_q      <= '0;
      ptr_q       <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
      rem_done_q  <= 1'b0;
      ins_done_q  <= 1'b0;
      remove_en_q <= 1'b0;
      n_q         <= '0;
      start_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        wsize_q <= cfg_wdata_i;
        fill_q  <= '0;
        ptr_q   <= '0;
      end
      if (cmd_i.load) begin
        start_q <= in_data_i.start_of_sequence;
      end
      if (cmd_i.prep) begin
        fill_q      <= fill_c;
        ptr_q       <= ptr_c[AW-1:0];
        n_q         <= fill_c;
        remove_en_q <= (fill_c >= w_eff);
      end
      if (cmd_i.prime) begin
        j_q        <= '0;
        k_q        <= '0;
        rem_done_q <= 1'b0;
        ins_done_q <= 1'b0;
      end
      if (cmd_i.step) begin
        j_q        <= j_d;
        k_q        <= k_d;
        rem_done_q <= rem_done_d;
        ins_done_q <= ins_done_d;
      end
      if (cmd_i.commit) begin
        bank_q  <= ~bank_q;
        fill_q  <= fill_new;
        ptr_q   <= ptr_inc[AW-1:0];
        start_q <= 1'b0;
        if (result) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= in_data_i.sample;
    end
    if (cmd_i.prime) begin
      r_q    <= $signed(ring_rdata);
      low_q  <= '0;
      high_q <= '0;
    end
    if (wr_en) begin
      if (k_q == m_idx) begin
        med_q <= wr_val;
      end else if (k_q < m_idx) begin
        low_q <= low_q + ACC_W'(wr_val);
      end else begin
        high_q <= high_q + ACC_W'(wr_val);
      end
    end
    if (cmd_i.commit && result) begin
      out_q.window_cost   <= COST_W'($unsigned(cost_s));
      out_q.window_median <= med_q;
    end
  end

  assign status_o.merge_done = !avail && ins_done_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;

endmodule

// File: design/sliding_median_deviation_cost_core.sv
// ----------------------------------------------------------------------------
// sliding_median_deviation_cost_core
// Sliding window lower median and sum of absolute deviations from it.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a signed sample and a start flag (valid/ready). Output
//   beats carry the window cost and the lower median (valid/ready). Once the
//   window holds window_size samples, each input beat yields one output beat;
//   before that it yields none. Writing window_size (cfg_we_i) clears the
//   window, as does the start flag on a beat.
//   A beat is accepted only while the core is idle, so the next beat is not
//   taken until the current one has been committed. The sorted window lives
//   in a RAM pair and the merge pass moves one entry per cycle through a
//   single read port, so an item takes longer the more samples the window
//   holds before it (at most window_size).
//   A finished result sits in an output register; the next item is accepted
//   while it waits. If the receiver stalls, the following item finishes its
//   pass and then holds until the output register is free.
//   Reset clears the window and sets window_size to 1; no clearing pass runs.
// ----------------------------------------------------------------------------
module sliding_median_deviation_cost_core #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [10:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smdc_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output smdc_pkg::out_beat_t out_data_o
);
  import smdc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  smdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smdc_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !status.out_busy)
    else $error("commit while output register busy");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while item in flight");

  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("output valid without commit");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Sliding window median / deviation cost core: a scoreboard keeps its own
// sorted window, predicts the median and cost of each beat, and compares them
// with the output stream under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import smdc_pkg::*;

  localparam int unsigned WIN_MAX   = 1024;
  localparam int unsigned SETTLE_CY = WIN_MAX + 64;

  class median_cost_board;
    longint      arrival[WIN_MAX];
    longint      sorted_q[$];
    int unsigned ring_ptr;
    int unsigned wsize_reg;
    out_beat_t   cost_q[$];
    bit          failed;

    function new();
      wsize_reg = 1;
      ring_ptr  = 0;
      failed    = 0;
    endfunction

    function void set_window(logic [WSIZE_W-1:0] val);
      wsize_reg = 32'(val);
      sorted_q.delete();
      ring_ptr = 0;
    endfunction

    function void note_sample(in_beat_t b);
      longint      v;
      longint      med;
      longint      d;
      int unsigned w;
      int unsigned pos;
      longint      cost;
      out_beat_t   r;
      v = longint'(b.sample);
      w = (wsize_reg == 0) ? 1 : (wsize_reg > WIN_MAX) ? WIN_MAX : wsize_reg;
      if (b.start_of_sequence) begin
        sorted_q.delete();
        ring_ptr = 0;
      end
      if (ring_ptr >= w) ring_ptr = 0;
      // full window: drop the oldest sample (first equal entry)
      if (sorted_q.size() >= w) begin
        for (int i = 0; i < sorted_q.size(); i++) begin
          if (sorted_q[i] == arrival[ring_ptr]) begin
            sorted_q.delete(i);
            break;
          end
        end
      end
      pos = 0;
      while (pos < sorted_q.size() && sorted_q[pos] <= v) pos++;
      sorted_q.insert(pos, v);
      arrival[ring_ptr] = v;
      ring_ptr++;
      if (ring_ptr >= w) ring_ptr = 0;
      if (sorted_q.size() < w) return;
      med  = sorted_q[(w - 1) / 2];
      cost = 0;
      foreach (sorted_q[i]) begin
        d = sorted_q[i] - med;
        cost += (d < 0) ? -d : d;
      end
      r.window_cost   = cost[COST_W-1:0];
      r.window_median = med[SAMPLE_W-1:0];
      cost_q.push_back(r);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp_r;
      if (cost_q.size() == 0) begin
        $display("%0t: unexpected beat cost=%0d median=%0d", $time,
                 got.window_cost, got.window_median);
        failed = 1;
        return;
      end
      exp_r = cost_q.pop_front();
      if (got.window_cost !== exp_r.window_cost) begin
        $display("%0t: cost expected %0d actual %0d", $time,
                 exp_r.window_cost, got.window_cost);
        failed = 1;
      end
      if (got.window_median !== exp_r.window_median) begin
        $display("%0t: median expected %0d actual %0d", $time,
                 exp_r.window_median, got.window_median);
        failed = 1;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic [WSIZE_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  in_beat_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  out_beat_t          out_data_o;

  median_cost_board board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  sliding_median_deviation_cost_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  // entered and left at a falling edge
  task automatic send_beat(logic signed [SAMPLE_W-1:0] s, logic sos);
    in_beat_t b;
    b.sample            = s;
    b.start_of_sequence = sos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.cost_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CY) @(negedge clk_i);
  endtask

  task automatic write_window(logic [WSIZE_W-1:0] val);
    drain();
    cfg_we_i    <= 1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.set_window(val);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return SAMPLE_W'($signed($urandom_range(16)) - 8);
      4:          return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default:    return $urandom;
    endcase
  endfunction

  task automatic random_phase(logic [WSIZE_W-1:0] wsize, int unsigned count);
    write_window(wsize);
    for (int unsigned i = 0; i < count; i++) begin
      send_beat(pick_sample(), ($urandom_range(39) == 0));
    end
  endtask

  initial begin
    int unsigned sizes[10] = '{3, 2, 5, 8, 16, 7, 64, 4, 33, 1};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // reset default window of one
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h7fff_ffff, 1'b0);
    send_beat(32'h0000_0000, 1'b1);
    send_beat(32'hffff_ffff, 1'b0);
    write_window(WSIZE_W'(0));             // behaves as one
    send_beat(32'h1234_5678, 1'b0);
    send_beat(32'hedcb_a987, 1'b1);
    write_window(WSIZE_W'(2));             // even window, widest spread
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h7fff_ffff, 1'b0);
    send_beat(32'h7fff_ffff, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h0000_0005, 1'b1);        // restart: no beat yet
    send_beat(32'hffff_fffb, 1'b0);
    write_window(WSIZE_W'(4));             // duplicates in the window
    send_beat(32'h0000_0007, 1'b0);
    send_beat(32'h0000_0007, 1'b0);
    send_beat(32'hffff_fff9, 1'b0);
    send_beat(32'h0000_0007, 1'b0);
    send_beat(32'h0000_0007, 1'b0);
    send_beat(32'hffff_fff9, 1'b0);

    for (int p = 0; p < 10; p++) begin
      if (p == 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 24;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (p == 0) begin
        send_idle_pct = 24;
        recv_idle_pct = 69;
      end
      random_phase(WSIZE_W'(sizes[p]), 100);
    end
    // above the maximum: clamps to the largest window
    random_phase(WSIZE_W'(2047), WIN_MAX + 6);

    drain();
    if (!board.failed && board.cost_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(64'd200_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
